@@ rtl/ccfg_pkg.sv @@
// ----------------------------------------------------------------------------
// ccfg_pkg: shared types and constants of the charger frame generator
// Queue entry, configuration bundle, frame record, sequencer states and the
// CRC-8 byte step used by the back end.
// ----------------------------------------------------------------------------
package ccfg_pkg;

  localparam logic [7:0] CRC_POLY = 8'h85;
  localparam logic [7:0] PWR_ZERO = 8'h64;
  localparam logic [7:0] PWR_MAX  = 8'hA0;
  // setpoint quotient above this clamps to PWR_MAX (0x64 + 60 = 0xA0)
  localparam logic [9:0] PWR_SPAN = 10'd60;

  // floor(p / 100) = (p * DIV100_RECIP) >> DIV100_SHIFT for any 16-bit p
  localparam logic [16:0] DIV100_RECIP = 17'd83887;
  localparam int unsigned DIV100_SHIFT = 23;

  localparam logic [10:0] ID_STATUS = 11'h1DB;
  localparam logic [10:0] ID_FIXED  = 11'h50B;
  localparam logic [10:0] ID_LIMIT  = 11'h1DC;
  localparam logic [10:0] ID_POWER  = 11'h1F2;
  localparam logic [10:0] ID_SLOW_A = 11'h55B;
  localparam logic [10:0] ID_SLOW_B = 11'h59E;
  localparam logic [10:0] ID_SLOW_C = 11'h5BC;

  localparam logic [3:0] LEN_SHORT = 4'd7;
  localparam logic [3:0] LEN_FULL  = 4'd8;

  typedef enum logic [7:0] {
    REG_VOLTAGE_SP = 8'd0,
    REG_POWER_SP   = 8'd1,
    REG_CHARGE_EN  = 8'd2
  } reg_idx_e;

  typedef enum logic [0:0] {
    TICK_FAST = 1'b0,
    TICK_SLOW = 1'b1
  } tick_e;

  typedef enum logic [2:0] {
    FK_STATUS,
    FK_FIXED,
    FK_LIMIT,
    FK_POWER,
    FK_SLOW_A,
    FK_SLOW_B,
    FK_SLOW_C
  } frame_kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CRC,
    ST_MIN,
    ST_MUL,
    ST_CMD,
    ST_EMIT
  } back_state_e;

  typedef struct packed {
    logic [9:0]  voltage_sp;
    logic [15:0] power_sp;
    logic        charge_en;
  } cfg_t;

  // classified tick, as it waits in the queue
  typedef struct packed {
    tick_e       mode;
    logic        charging;
    logic [7:0]  cur_hi;
    logic [7:0]  cur_lo;
    logic [7:0]  vol_hi;
    logic [7:0]  vol_lo;
    logic [9:0]  volts;
    logic [15:0] lim;
  } entry_t;

  typedef struct packed {
    logic [10:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] data;
    logic            last;
  } frame_t;

  // one data byte into the CRC-8 register, msb first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] crc;
    logic       top;
    crc = crc_in;
    for (int i = 7; i >= 0; i--) begin
      top = crc[7];
      crc = {crc[6:0], data[i]};
      if (top) begin
        crc = crc ^ CRC_POLY;
      end
    end
    return crc;
  endfunction

endpackage

@@ rtl/charger_can_frame_generator_top.sv @@
// ----------------------------------------------------------------------------
// charger_can_frame_generator_top: periodic CAN frames of an on-board charger
// Turns 10 ms and 100 ms ticks into the charger's status, limit, power and
// housekeeping frames, with rolling counters and CRC-8 where the frame has one.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                | word
//  --------+-----------+--------------------------+--------------------------
//  cfg     | in        | cfg_valid_i/cfg_ready_o  | cfg_index_i, cfg_data_i
//  tick    | in        | in_valid_i/in_ready_o    | mode_i .. bms_current_limit_i
//  frame   | out       | out_valid_o/out_ready_i  | frame_id_o .. last_frame_o
//
//  A 10 ms tick yields four frames, a 100 ms tick three frames; the CRC runs
//  one byte per cycle in the back sequencer, and the power path passes through
//  its min, multiply and command steps before its frame.
//  Ticks are taken into a QUEUE_DEPTH-word queue while the sequencer works.
//  Reset clears counters, commanded power, setpoints and the queue at once.
//  A stalled output holds its word and the sequencer waits on it.
// ----------------------------------------------------------------------------
module charger_can_frame_generator_top
  import ccfg_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [7:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               mode_i,
  input  logic               in_charge_mode_i,
  input  logic signed [15:0] current_fixed_i,
  input  logic signed [15:0] voltage_fixed_i,
  input  logic [9:0]         battery_volts_i,
  input  logic [8:0]         bms_current_limit_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [10:0]        frame_id_o,
  output logic [3:0]         frame_len_o,
  output logic [7:0]         byte_zero_o,
  output logic [7:0]         byte_one_o,
  output logic [7:0]         byte_two_o,
  output logic [7:0]         byte_three_o,
  output logic [7:0]         byte_four_o,
  output logic [7:0]         byte_five_o,
  output logic [7:0]         byte_six_o,
  output logic [7:0]         byte_seven_o,
  output logic               last_frame_o
);

  cfg_t   cfg;
  entry_t push_entry, head_entry;
  logic   q_push, q_pop, q_full, q_empty;
  frame_t frame;

  ccfg_front u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i),
    .in_valid_i          (in_valid_i),
    .in_ready_o          (in_ready_o),
    .mode_i              (mode_i),
    .in_charge_mode_i    (in_charge_mode_i),
    .current_fixed_i     (current_fixed_i),
    .voltage_fixed_i     (voltage_fixed_i),
    .battery_volts_i     (battery_volts_i),
    .bms_current_limit_i (bms_current_limit_i),
    .q_full_i            (q_full),
    .q_push_o            (q_push),
    .q_entry_o           (push_entry),
    .cfg_o               (cfg)
  );

  ccfg_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .entry_i (push_entry),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .entry_o (head_entry)
  );

  ccfg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .q_empty_i   (q_empty),
    .q_entry_i   (head_entry),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_frame_o (frame)
  );

  assign frame_id_o   = frame.id;
  assign frame_len_o  = frame.len;
  assign byte_zero_o  = frame.data[0];
  assign byte_one_o   = frame.data[1];
  assign byte_two_o   = frame.data[2];
  assign byte_three_o = frame.data[3];
  assign byte_four_o  = frame.data[4];
  assign byte_five_o  = frame.data[5];
  assign byte_six_o   = frame.data[6];
  assign byte_seven_o = frame.data[7];
  assign last_frame_o = frame.last;

endmodule

@@ rtl/ccfg_front.sv @@
// ----------------------------------------------------------------------------
// ccfg_front: configuration registers and tick intake
// Holds the setpoints, takes ticks while the queue has room and
// preformats the status words and the volts-times-limit product.
// ----------------------------------------------------------------------------
module ccfg_front
  import ccfg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [7:0]          cfg_index_i,
  input  logic [15:0]         cfg_data_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                mode_i,
  input  logic                in_charge_mode_i,
  input  logic signed [15:0]  current_fixed_i,
  input  logic signed [15:0]  voltage_fixed_i,
  input  logic [9:0]          battery_volts_i,
  input  logic [8:0]          bms_current_limit_i,
  input  logic                q_full_i,
  output logic                q_push_o,
  output entry_t              q_entry_o,
  output cfg_t                cfg_o
);

  cfg_t        cfg_q, cfg_d;
  logic [18:0] lim_full;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_VOLTAGE_SP: cfg_d.voltage_sp = cfg_data_i[9:0];
        REG_POWER_SP:   cfg_d.power_sp   = cfg_data_i;
        REG_CHARGE_EN:  cfg_d.charge_en  = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

  assign in_ready_o = !q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  assign lim_full = 19'(battery_volts_i) * 19'(bms_current_limit_i);

  // current word is doubled, voltage word is quadrupled
  always_comb begin
    q_entry_o.mode     = tick_e'(mode_i);
    q_entry_o.charging = in_charge_mode_i;
    q_entry_o.cur_hi   = current_fixed_i[14:7];
    q_entry_o.cur_lo   = {current_fixed_i[6:4], 5'b00000};
    q_entry_o.vol_hi   = voltage_fixed_i[13:6];
    q_entry_o.vol_lo   = {voltage_fixed_i[5:4], 6'b101011};
    q_entry_o.volts    = battery_volts_i;
    q_entry_o.lim      = lim_full[15:0];
  end

endmodule

@@ rtl/ccfg_queue.sv @@
// ----------------------------------------------------------------------------
// ccfg_queue: tick queue between intake and frame sequencer
// Small circular buffer of classified ticks; push and pop may share a cycle.
// ----------------------------------------------------------------------------
module ccfg_queue
  import ccfg_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  entry_t entry_i,
  output logic   full_o,
  input  logic   pop_i,
  output logic   empty_o,
  output entry_t entry_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  entry_t             slot_q [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0]   count_q, count_d;

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign entry_o = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/ccfg_back.sv @@
// ----------------------------------------------------------------------------
// ccfg_back: frame sequencer
// Walks the frames of one tick, runs the CRC one byte per cycle, updates the
// commanded power and hands each frame to the output register.
// ----------------------------------------------------------------------------
module ccfg_back
  import ccfg_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  cfg_t   cfg_i,
  input  logic   q_empty_i,
  input  entry_t q_entry_i,
  output logic   q_pop_o,
  output logic   out_valid_o,
  input  logic   out_ready_i,
  output frame_t out_frame_o
);

  back_state_e state_q, state_d;
  entry_t      ent_q, ent_d;
  logic [1:0]  frame_q, frame_d;
  logic [2:0]  byte_q, byte_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] pwr_q, pwr_d;
  logic [9:0]  quot_q, quot_d;
  logic [1:0]  cnt_status_q, cnt_status_d;
  logic [1:0]  cnt_limit_q, cnt_limit_d;
  logic [1:0]  cnt_power_q, cnt_power_d;
  logic [1:0]  cnt_slow_q, cnt_slow_d;
  logic [7:0]  cmd_q, cmd_d;
  logic        out_valid_q, out_valid_d;
  frame_t      out_q, out_d;

  frame_kind_e kind, kind_next;
  logic [7:0]  dat [8];
  logic [10:0] fid;
  logic [3:0]  flen;
  logic [7:0]  fb7;
  logic        flast;
  logic [32:0] prod;
  logic [7:0]  sp;
  logic        slot_free;

  function automatic frame_kind_e kind_of(input tick_e mode, input logic [1:0] frame);
    frame_kind_e k;
    case ({mode, frame})
      3'b000:  k = FK_STATUS;
      3'b001:  k = FK_FIXED;
      3'b010:  k = FK_LIMIT;
      3'b011:  k = FK_POWER;
      3'b100:  k = FK_SLOW_A;
      3'b101:  k = FK_SLOW_B;
      default: k = FK_SLOW_C;
    endcase
    return k;
  endfunction

  function automatic back_state_e first_state(input frame_kind_e k);
    back_state_e s;
    case (k)
      FK_STATUS, FK_LIMIT, FK_SLOW_A: s = ST_CRC;
      FK_POWER:                       s = ST_MIN;
      default:                        s = ST_EMIT;
    endcase
    return s;
  endfunction

  assign kind      = kind_of(ent_q.mode, frame_q);
  assign kind_next = kind_of(ent_q.mode, frame_q + 2'd1);

  // frame contents; byte 7 of the CRC frames comes from crc_q
  always_comb begin
    dat[0] = 8'h00; dat[1] = 8'h00; dat[2] = 8'h00; dat[3] = 8'h00;
    dat[4] = 8'h00; dat[5] = 8'h00; dat[6] = 8'h00; dat[7] = 8'h00;
    fid   = ID_FIXED;
    flen  = LEN_FULL;
    fb7   = 8'h00;
    flast = 1'b0;
    case (kind)
      FK_STATUS: begin
        fid = ID_STATUS;
        dat[0] = ent_q.cur_hi; dat[1] = ent_q.cur_lo;
        dat[2] = ent_q.vol_hi; dat[3] = ent_q.vol_lo;
        dat[4] = 8'h40; dat[6] = {6'b0, cnt_status_q};
        fb7 = crc_q;
      end
      FK_FIXED: begin
        fid = ID_FIXED;
        flen = LEN_SHORT;
        dat[2] = 8'h06; dat[3] = 8'hC0;
      end
      FK_LIMIT: begin
        fid = ID_LIMIT;
        dat[0] = 8'h6E; dat[1] = 8'h0A; dat[2] = 8'h05; dat[3] = 8'hD5;
        dat[6] = {6'b0, cnt_limit_q};
        fb7 = crc_q;
      end
      FK_POWER: begin
        fid = ID_POWER;
        dat[0] = 8'h30; dat[1] = cmd_q; dat[2] = 8'h20; dat[3] = 8'hAC;
        dat[5] = 8'h3C; dat[6] = {6'b0, cnt_power_q};
        fb7 = 8'h8F;
        flast = 1'b1;
      end
      FK_SLOW_A: begin
        fid = ID_SLOW_A;
        dat[0] = 8'hA4; dat[1] = 8'h40; dat[2] = 8'hAA;
        dat[4] = 8'hDF; dat[5] = 8'hC0; dat[6] = {6'b000100, cnt_slow_q};
        fb7 = crc_q;
      end
      FK_SLOW_B: begin
        fid = ID_SLOW_B;
        dat[2] = 8'h0C; dat[3] = 8'h76; dat[4] = 8'h18;
      end
      FK_SLOW_C: begin
        fid = ID_SLOW_C;
        dat[0] = 8'h3D; dat[1] = 8'h80; dat[2] = 8'hF0; dat[3] = 8'h64;
        dat[4] = 8'hB0; dat[5] = 8'h01;
        fb7 = 8'h32;
        flast = 1'b1;
      end
      default: begin
        fid = ID_FIXED;
      end
    endcase
  end

  assign prod = 33'(pwr_q) * 33'(DIV100_RECIP);
  assign sp   = (quot_q > PWR_SPAN) ? PWR_MAX : quot_q[7:0] + PWR_ZERO;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    ent_d        = ent_q;
    frame_d      = frame_q;
    byte_d       = byte_q;
    crc_d        = crc_q;
    pwr_d        = pwr_q;
    quot_d       = quot_q;
    cnt_status_d = cnt_status_q;
    cnt_limit_d  = cnt_limit_q;
    cnt_power_d  = cnt_power_q;
    cnt_slow_d   = cnt_slow_q;
    cmd_d        = cmd_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    q_pop_o      = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          // every tick opens with a CRC frame
          q_pop_o = 1'b1;
          ent_d   = q_entry_i;
          frame_d = 2'd0;
          byte_d  = 3'd0;
          crc_d   = 8'h00;
          state_d = ST_CRC;
        end
      end
      ST_CRC: begin
        crc_d  = crc8_byte(crc_q, dat[byte_q]);
        byte_d = byte_q + 3'd1;
        if (byte_q == 3'd7) begin
          state_d = ST_EMIT;
        end
      end
      ST_MIN: begin
        pwr_d   = (cfg_i.power_sp < ent_q.lim) ? cfg_i.power_sp : ent_q.lim;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        quot_d  = prod[DIV100_SHIFT +: 10];
        state_d = ST_CMD;
      end
      ST_CMD: begin
        if (ent_q.charging && cfg_i.charge_en) begin
          cmd_d = (ent_q.volts < cfg_i.voltage_sp) ? sp : cmd_q - 8'd1;
        end else begin
          cmd_d = PWR_ZERO;
        end
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_d.id    = fid;
          out_d.len   = flen;
          out_d.last  = flast;
          for (int j = 0; j < 7; j++) begin
            out_d.data[j] = dat[j];
          end
          out_d.data[7] = fb7;
          case (kind)
            FK_STATUS: cnt_status_d = cnt_status_q + 2'd1;
            FK_LIMIT:  cnt_limit_d  = cnt_limit_q + 2'd1;
            FK_POWER:  cnt_power_d  = cnt_power_q + 2'd1;
            FK_SLOW_A: cnt_slow_d   = cnt_slow_q + 2'd1;
            default:   cnt_slow_d   = cnt_slow_q;
          endcase
          if (flast) begin
            state_d = ST_IDLE;
          end else begin
            frame_d = frame_q + 2'd1;
            byte_d  = 3'd0;
            crc_d   = 8'h00;
            state_d = first_state(kind_next);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cnt_status_q <= '0;
      cnt_limit_q  <= '0;
      cnt_power_q  <= '0;
      cnt_slow_q   <= '0;
      cmd_q        <= '0;
      out_valid_q  <= 1'b0;
      frame_q      <= '0;
      byte_q       <= '0;
    end else begin
      state_q      <= state_d;
      cnt_status_q <= cnt_status_d;
      cnt_limit_q  <= cnt_limit_d;
      cnt_power_q  <= cnt_power_d;
      cnt_slow_q   <= cnt_slow_d;
      cmd_q        <= cmd_d;
      out_valid_q  <= out_valid_d;
      frame_q      <= frame_d;
      byte_q       <= byte_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q  <= ent_d;
    crc_q  <= crc_d;
    pwr_q  <= pwr_d;
    quot_q <= quot_d;
    out_q  <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_frame_o = out_q;

endmodule
